// ===== hdl/skhi_pkg.sv =====
// Package of shared types and constants for the string key hash index.
`timescale 1ns / 1ps
package skhi_pkg;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   localparam int          KEY_BYTES  = 15;
   localparam int          KEY_BITS   = 120;
   localparam logic [31:0] HASH_SEED  = 32'd5381;
   localparam logic [7:0]  CHAR_FIRST = 8'd32;
   localparam logic [7:0]  CHAR_END   = 8'd127;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key_low;
      logic [55:0] key_high;
      logic [23:0] node_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [23:0] found_value;
   } rsp_type;
endpackage

// ===== hdl/skhi_if.sv =====
// Valid and ready channel interface carrying one payload word.
`timescale 1ns / 1ps
interface skhi_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/skhi_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module skhi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== hdl/skhi_hash.sv =====
// Iterative key normaliser and djb2 hash unit, one byte per cycle.
`timescale 1ns / 1ps
module skhi_hash #(
   parameter int KEY_CHARS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [skhi_pkg::KEY_BITS-1:0] raw_key,
   output logic                       done,
   output logic [skhi_pkg::KEY_BITS-1:0] norm_key,
   output logic [31:0]                hash
);
   logic [skhi_pkg::KEY_BITS-1:0] raw_ff, raw_in, key_ff, key_in;
   logic [31:0] hash_ff, hash_in;
   logic [3:0]  pos_ff, pos_in, kept_ff, kept_in;
   logic        busy_ff, busy_in;
   logic [7:0]  ch;

   assign ch       = raw_ff[7:0];
   assign done     = busy_ff && (pos_ff == 4'(KEY_CHARS) || ch == 8'd0);
   assign norm_key = key_ff;
   assign hash     = hash_ff;

   always_comb begin
      raw_in  = raw_ff;
      key_in  = key_ff;
      hash_in = hash_ff;
      pos_in  = pos_ff;
      kept_in = kept_ff;
      busy_in = busy_ff;
      if (start) begin
         raw_in  = raw_key;
         key_in  = '0;
         hash_in = skhi_pkg::HASH_SEED;
         pos_in  = '0;
         kept_in = '0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         raw_in = raw_ff >> 8;
         pos_in = pos_ff + 4'd1;
         if (ch >= skhi_pkg::CHAR_FIRST && ch < skhi_pkg::CHAR_END) begin
            key_in[kept_ff*8 +: 8] = ch;
            kept_in = kept_ff + 4'd1;
            hash_in = (hash_ff << 5) + hash_ff + {24'd0, ch};
         end
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      key_ff  <= key_in;
      hash_ff <= hash_in;
      pos_ff  <= pos_in;
      kept_ff <= kept_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end
endmodule

// ===== hdl/skhi_mod.sv =====
// Iterative restoring modulo unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module skhi_mod #(
   parameter int DIV_BITS = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] remainder
);
   logic [31:0]       num_ff, num_in;
   logic [DIV_BITS:0] rem_ff, rem_in, trial;
   logic [DIV_BITS-1:0] div_ff, div_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   assign done      = busy_ff && cnt_ff == 6'd32;
   assign remainder = rem_ff[DIV_BITS-1:0];
   assign trial     = {rem_ff[DIV_BITS-1:0], num_ff[31]};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 6'd1;
         rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end
endmodule

// ===== hdl/string_key_hash_index.sv =====
// Top level of the string key hash index with its probe sequencer.
//
//  Channel  Direction  Payload
//  req      in         command, key_low, key_high, node_value
//  rsp      out        status, found_value
//  csr      in         table_size (write only)
//
// An item is hashed, reduced modulo the table size, then probed slot by slot
// through the slot memories, which share one address; each probe passes S_READ and S_CHECK.
// A clear sweeps the used bits of all TABLE_DEPTH slots; after reset the
// same sweep runs before the first word is taken.
// The result holds until taken; a new word is taken once it has gone.
`timescale 1ns / 1ps
module string_key_hash_index #(
   parameter int TABLE_DEPTH = 4096,
   parameter int KEY_CHARS   = 15,
   parameter int VALUE_BITS  = 24
) (
   input  logic  clock,
   input  logic  reset,
   skhi_if.sink   req,
   skhi_if.source rsp,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = AW + 1;
   localparam int EW = skhi_pkg::KEY_BITS + VALUE_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [12:0] size_reg_ff;
   logic [SW-1:0] size;
   logic [1:0]  cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [SW-1:0] probes_ff, probes_in;
   logic [2:0]  status_ff, status_in;
   logic [23:0] out_ff, out_in;
   logic        hash_start, hash_done, mod_start, mod_done;
   logic [skhi_pkg::KEY_BITS-1:0] norm_key;
   logic [31:0] hash;
   logic [SW-1:0] rem;
   logic        used_we, used_wd, used_rd, ent_we;
   logic [EW-1:0] ent_rd;
   logic [AW-1:0] next_slot;

   always_comb begin
      if (size_reg_ff == 13'd0) size = SW'(1);
      else if (32'(size_reg_ff) > TABLE_DEPTH) size = SW'(TABLE_DEPTH);
      else size = SW'(size_reg_ff);
   end

   skhi_hash #(.KEY_CHARS(KEY_CHARS)) u_hash (
      .clock, .reset, .start(hash_start),
      .raw_key({req.payload.key_high, req.payload.key_low}),
      .done(hash_done), .norm_key, .hash
   );

   skhi_mod #(.DIV_BITS(SW)) u_mod (
      .clock, .reset, .start(mod_start), .dividend(hash), .divisor(size),
      .done(mod_done), .remainder(rem)
   );

   skhi_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
      .clock, .wr_en(used_we), .addr(slot_ff), .wr_data(used_wd), .rd_data(used_rd)
   );

   skhi_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry (
      .clock, .wr_en(ent_we), .addr(slot_ff), .wr_data({val_ff, norm_key}),
      .rd_data(ent_rd)
   );

   assign next_slot = (SW'(slot_ff) + SW'(1) == size) ? '0 : slot_ff + AW'(1);
   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = state_ff == S_RESP;
   assign rsp.payload.status = status_ff;
   assign rsp.payload.found_value = out_ff;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      val_in     = val_ff;
      slot_in    = slot_ff;
      probes_in  = probes_ff;
      status_in  = status_ff;
      out_in     = out_ff;
      hash_start = 1'b0;
      mod_start  = 1'b0;
      used_we    = 1'b0;
      used_wd    = 1'b0;
      ent_we     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            used_we = 1'b1;
            slot_in = slot_ff + AW'(1);
            if (slot_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = (status_ff == skhi_pkg::ST_CLEARED) ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               cmd_in    = req.payload.command;
               val_in    = VALUE_BITS'(req.payload.node_value);
               status_in = skhi_pkg::ST_NOT_FOUND;
               out_in    = '0;
               slot_in   = '0;
               probes_in = '0;
               case (req.payload.command)
                  skhi_pkg::CMD_CLEAR: begin
                     status_in = skhi_pkg::ST_CLEARED;
                     state_in  = S_CLEAR;
                  end
                  skhi_pkg::CMD_INSERT, skhi_pkg::CMD_LOOKUP: begin
                     hash_start = 1'b1;
                     state_in   = S_HASH;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_HASH: begin
            if (hash_done) begin
               mod_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               slot_in  = rem[AW-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (probes_ff == size) begin
               status_in = (cmd_ff == skhi_pkg::CMD_INSERT) ?
                           skhi_pkg::ST_FULL : skhi_pkg::ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!used_rd) begin
               if (cmd_ff == skhi_pkg::CMD_INSERT) begin
                  used_we   = 1'b1;
                  used_wd   = 1'b1;
                  ent_we    = 1'b1;
                  status_in = skhi_pkg::ST_INSERTED;
               end
               state_in = S_RESP;
            end else if (ent_rd[skhi_pkg::KEY_BITS-1:0] == norm_key) begin
               status_in = (cmd_ff == skhi_pkg::CMD_INSERT) ?
                           skhi_pkg::ST_DUPLICATE : skhi_pkg::ST_FOUND;
               out_in    = 24'(ent_rd[EW-1:skhi_pkg::KEY_BITS]);
               state_in  = S_RESP;
            end else begin
               slot_in   = next_slot;
               probes_in = probes_ff + SW'(1);
               state_in  = S_READ;
            end
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      probes_ff <= probes_in;
      out_ff    <= out_in;
      if (reset) begin
         state_ff  <= S_CLEAR;
         slot_ff   <= '0;
         status_ff <= skhi_pkg::ST_NOT_FOUND;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         status_ff <= status_in;
      end
      if (reset) begin
         size_reg_ff <= 13'd4096;
      end else if (csr_wr_en) begin
         size_reg_ff <= csr_wr_data;
      end
   end
endmodule
